// File: src/trag_pkg.sv
// ----------------------------------------------------------------------------
// Tensor roll address generator package
// Shared widths, register indexes, configuration types and helpers.
// ----------------------------------------------------------------------------
package trag_pkg;

  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_INDEX_BITS  = 32;
  localparam int DEF_VALUE_BITS  = 64;

  localparam int PACKED_DIMS     = 4;
  localparam int PACKED_IDX_BITS = 2;
  localparam int DIM_BITS        = 16;
  localparam int STRIDE_BITS     = 32;
  localparam int STEP_BITS       = 5;
  localparam int TOTAL_BITS      = 32;
  localparam int DEST_KEEP_BITS  = 32;
  localparam int ACTIVE_BITS     = 3;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_DIMS     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_ELEMENTS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SIZES       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLDS      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_RANGE_ZERO  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_RANGE_ONE   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_RANGE_TWO   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_RANGE_THREE = 3'd7;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_LOAD_STRIDE,
    CFG_STRIDE,
    CFG_LOAD_THRESH,
    CFG_THRESH
  } cfg_state_t;

  typedef struct packed {
    logic [STRIDE_BITS-1:0] stride;
    logic [DIM_BITS-1:0]    size;
    logic [DIM_BITS-1:0]    shift;
    logic                   used;
  } lane_cfg_t;

  function automatic int lane_latency(input int index_bits);
    return 2 * index_bits + 2;
  endfunction

endpackage

// File: src/trag_cfg.sv
// ----------------------------------------------------------------------------
// Tensor roll configuration
// Register file and a sequential divider that derives stride and roll shift
// for each dimension after every register write.
// ----------------------------------------------------------------------------
module trag_cfg #(
  parameter int LANES = trag_pkg::PACKED_DIMS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [trag_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [trag_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic [trag_pkg::TOTAL_BITS-1:0]       total_elements,
  output trag_pkg::lane_cfg_t                   lane_cfg [LANES],
  output logic                                  busy
);

  localparam int DW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int DB = trag_pkg::DIM_BITS;
  localparam int SB = trag_pkg::STRIDE_BITS;
  localparam logic [trag_pkg::STEP_BITS-1:0] LAST_STEP = trag_pkg::STEP_BITS'(SB - 1);

  logic [trag_pkg::ACTIVE_BITS-1:0] active_dims;
  logic [trag_pkg::CFG_DATA_BITS-1:0] dim_sizes;
  logic [trag_pkg::CFG_DATA_BITS-1:0] thresholds;
  logic [SB-1:0] dim_ranges [trag_pkg::PACKED_DIMS];
  logic [DB-1:0] size_f [trag_pkg::PACKED_DIMS];
  logic [DB-1:0] thr_f [trag_pkg::PACKED_DIMS];

  trag_pkg::cfg_state_t state, state_next;
  logic [DW-1:0] dim;
  logic [trag_pkg::STEP_BITS-1:0] step;
  logic [DB-1:0] rem, rem_next;
  logic [SB-1:0] quo, quo_next;
  logic [SB-1:0] dvd;
  logic [SB-1:0] stride [LANES];
  logic [DB-1:0] shift [LANES];

  logic wr;
  logic [DB-1:0] div_size;
  logic [DB:0] trial;
  logic ge;
  logic last;

  assign wr = cfg_valid && cfg_ready;

  for (genvar p = 0; p < trag_pkg::PACKED_DIMS; p++) begin : g_fields
    assign size_f[p] = dim_sizes[p*DB +: DB];
    assign thr_f[p]  = thresholds[p*DB +: DB];
  end

  assign div_size = size_f[trag_pkg::PACKED_IDX_BITS'(dim)];
  assign trial    = {rem, dvd[SB-1]};
  assign ge       = trial >= {1'b0, div_size};
  assign rem_next = ge ? DB'(trial - {1'b0, div_size}) : trial[DB-1:0];
  assign quo_next = {quo[SB-2:0], ge};
  assign last     = step == LAST_STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims    <= trag_pkg::ACTIVE_BITS'(1);
      total_elements <= '0;
      dim_sizes      <= '0;
      thresholds     <= '0;
      for (int p = 0; p < trag_pkg::PACKED_DIMS; p++) begin
        dim_ranges[p] <= '0;
      end
    end else if (wr) begin
      unique case (cfg_index)
        trag_pkg::REG_ACTIVE_DIMS:     active_dims <= cfg_data[trag_pkg::ACTIVE_BITS-1:0];
        trag_pkg::REG_TOTAL_ELEMENTS:  total_elements <= cfg_data[trag_pkg::TOTAL_BITS-1:0];
        trag_pkg::REG_DIM_SIZES:       dim_sizes <= cfg_data;
        trag_pkg::REG_THRESHOLDS:      thresholds <= cfg_data;
        trag_pkg::REG_DIM_RANGE_ZERO:  dim_ranges[0] <= cfg_data[SB-1:0];
        trag_pkg::REG_DIM_RANGE_ONE:   dim_ranges[1] <= cfg_data[SB-1:0];
        trag_pkg::REG_DIM_RANGE_TWO:   dim_ranges[2] <= cfg_data[SB-1:0];
        trag_pkg::REG_DIM_RANGE_THREE: dim_ranges[3] <= cfg_data[SB-1:0];
      endcase
    end
  end

  always_comb begin
    state_next = state;
    if (wr) begin
      state_next = trag_pkg::CFG_LOAD_STRIDE;
    end else begin
      unique case (state)
        trag_pkg::CFG_IDLE:        state_next = trag_pkg::CFG_IDLE;
        trag_pkg::CFG_LOAD_STRIDE: state_next = trag_pkg::CFG_STRIDE;
        trag_pkg::CFG_STRIDE: begin
          if (last) state_next = trag_pkg::CFG_LOAD_THRESH;
        end
        trag_pkg::CFG_LOAD_THRESH: state_next = trag_pkg::CFG_THRESH;
        trag_pkg::CFG_THRESH: begin
          if (last) begin
            state_next = (dim == DW'(LANES - 1)) ? trag_pkg::CFG_IDLE
                                                 : trag_pkg::CFG_LOAD_STRIDE;
          end
        end
        default: state_next = trag_pkg::CFG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trag_pkg::CFG_IDLE;
      dim   <= '0;
    end else begin
      state <= state_next;
      if (wr) begin
        dim <= '0;
      end else if (state == trag_pkg::CFG_THRESH && last) begin
        dim <= DW'(dim + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      trag_pkg::CFG_LOAD_STRIDE: begin
        dvd  <= dim_ranges[trag_pkg::PACKED_IDX_BITS'(dim)];
        rem  <= '0;
        quo  <= '0;
        step <= '0;
      end
      trag_pkg::CFG_LOAD_THRESH: begin
        dvd  <= SB'(thr_f[trag_pkg::PACKED_IDX_BITS'(dim)]);
        rem  <= '0;
        quo  <= '0;
        step <= '0;
      end
      trag_pkg::CFG_STRIDE, trag_pkg::CFG_THRESH: begin
        dvd  <= {dvd[SB-2:0], 1'b0};
        rem  <= rem_next;
        quo  <= quo_next;
        step <= trag_pkg::STEP_BITS'(step + 1'b1);
        if (last && state == trag_pkg::CFG_STRIDE) begin
          stride[dim] <= quo_next;
        end
        if (last && state == trag_pkg::CFG_THRESH) begin
          shift[dim] <= (rem_next == '0) ? '0 : DB'(div_size - rem_next);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy      = state != trag_pkg::CFG_IDLE;
    cfg_ready = 1'b1;
    for (int d = 0; d < LANES; d++) begin
      lane_cfg[d].stride = stride[d];
      lane_cfg[d].size   = size_f[d];
      lane_cfg[d].shift  = shift[d];
      lane_cfg[d].used   = ({1'b0, active_dims} > 4'(d)) && (size_f[d] != '0)
                           && (stride[d] != '0);
    end
  end

endmodule

// File: src/trag_lane.sv
// ----------------------------------------------------------------------------
// Tensor roll lane
// Pipelined offset of one dimension: coordinate by two restoring dividers,
// rotation, then change in coordinate times stride.
// ----------------------------------------------------------------------------
module trag_lane #(
  parameter int INDEX_BITS = trag_pkg::DEF_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [INDEX_BITS-1:0]  idx,
  input  trag_pkg::lane_cfg_t    cfg,
  output logic [INDEX_BITS-1:0]  delta
);

  localparam int SB = trag_pkg::STRIDE_BITS;
  localparam int DB = trag_pkg::DIM_BITS;

  logic [SB-1:0]         qrem [INDEX_BITS];
  logic [INDEX_BITS-1:0] qdvd [INDEX_BITS];
  logic [INDEX_BITS-1:0] qquo [INDEX_BITS+1];
  logic [DB-1:0]         mrem [INDEX_BITS+1];
  logic [INDEX_BITS-1:0] mdvd [INDEX_BITS];
  logic [DB:0]           diff;
  logic [DB:0]           rot_sum;
  logic [DB-1:0]         moved;
  logic signed [SB+DB+1:0] product;

  assign qrem[0] = '0;
  assign qdvd[0] = idx;
  assign qquo[0] = '0;

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_quo
    logic [SB:0] t;
    logic ge;
    assign t  = {qrem[k], qdvd[k][INDEX_BITS-1]};
    assign ge = t >= {1'b0, cfg.stride};
    always_ff @(posedge clk) begin
      if (en) begin
        qquo[k+1] <= {qquo[k][INDEX_BITS-2:0], ge};
      end
    end
    if (k < INDEX_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          qrem[k+1] <= ge ? SB'(t - {1'b0, cfg.stride}) : t[SB-1:0];
          qdvd[k+1] <= {qdvd[k][INDEX_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign mrem[0] = '0;
  assign mdvd[0] = qquo[INDEX_BITS];

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_mod
    logic [DB:0] t;
    logic ge;
    assign t  = {mrem[k], mdvd[k][INDEX_BITS-1]};
    assign ge = t >= {1'b0, cfg.size};
    always_ff @(posedge clk) begin
      if (en) begin
        mrem[k+1] <= ge ? DB'(t - {1'b0, cfg.size}) : t[DB-1:0];
      end
    end
    if (k < INDEX_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          mdvd[k+1] <= {mdvd[k][INDEX_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign rot_sum = {1'b0, mrem[INDEX_BITS]} + {1'b0, cfg.shift};
  assign moved   = (rot_sum >= {1'b0, cfg.size}) ? DB'(rot_sum - {1'b0, cfg.size})
                                                 : rot_sum[DB-1:0];
  assign product = $signed(diff) * $signed({1'b0, cfg.stride});

  always_ff @(posedge clk) begin
    if (en) begin
      diff  <= {1'b0, moved} - {1'b0, mrem[INDEX_BITS]};
      delta <= cfg.used ? product[INDEX_BITS-1:0] : '0;
    end
  end

endmodule

// File: src/tensor_roll_address_generator_core.sv
// ----------------------------------------------------------------------------
// Tensor roll address generator core
// Maps the linear index of each tensor element to its index after a roll
// over up to four dimensions; the element value passes through.
// ----------------------------------------------------------------------------
//  Channel  Signals                                          Direction
//  cfg      cfg_valid cfg_ready cfg_index cfg_data           write
//  in       in_valid in_ready source_index element_value     request in
//  out      out_valid out_ready dest_index moved_value       request out
//           out_of_range
//
// One request enters per cycle while in_ready is high; it drops while the
// output stalls with a request in the last stage or the configuration is
// busy. Each request passes the two bit-per-stage restoring dividers of each
// dimension lane. Every register write starts a stride and shift derivation
// for each lane in a shared serial divider; in_ready is low meanwhile.
// Reset is synchronous. A stall on the output freezes the pipeline only when
// its last stage holds a request, so bubbles are squeezed out meanwhile.
// ----------------------------------------------------------------------------
module tensor_roll_address_generator_core #(
  parameter int MAX_DIMS   = trag_pkg::DEF_MAX_DIMS,
  parameter int INDEX_BITS = trag_pkg::DEF_INDEX_BITS,
  parameter int VALUE_BITS = trag_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [trag_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [INDEX_BITS-1:0]               source_index,
  input  logic [VALUE_BITS-1:0]               element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [INDEX_BITS-1:0]               dest_index,
  output logic [VALUE_BITS-1:0]               moved_value,
  output logic                                out_of_range
);

  localparam int LANES = (MAX_DIMS < trag_pkg::PACKED_DIMS) ? MAX_DIMS
                                                           : trag_pkg::PACKED_DIMS;
  localparam int LAT   = trag_pkg::lane_latency(INDEX_BITS);
  localparam int CMPW  = (INDEX_BITS > trag_pkg::TOTAL_BITS) ? INDEX_BITS
                                                            : trag_pkg::TOTAL_BITS;
  localparam int KEEP  = (INDEX_BITS < trag_pkg::DEST_KEEP_BITS) ? INDEX_BITS
                                                                : trag_pkg::DEST_KEEP_BITS;

  logic [trag_pkg::TOTAL_BITS-1:0] total_elements;
  trag_pkg::lane_cfg_t lane_cfg [LANES];
  logic busy;

  logic                  vld [LAT+1];
  logic [INDEX_BITS-1:0] idx [LAT+1];
  logic [VALUE_BITS-1:0] val [LAT+1];
  logic                  oor [LAT+1];
  logic [INDEX_BITS-1:0] delta [LANES];

  logic en;
  logic out_free;
  logic [INDEX_BITS-1:0] offset;
  logic [INDEX_BITS-1:0] keep_mask;

  trag_cfg #(
    .LANES(LANES)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .total_elements (total_elements),
    .lane_cfg       (lane_cfg),
    .busy           (busy)
  );

  assign out_free = !out_valid || out_ready;
  assign en       = out_free || !vld[LAT];
  assign in_ready = en && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid && in_ready;
      for (int k = 0; k < LAT; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx[0] <= source_index;
      val[0] <= element_value;
      oor[0] <= CMPW'(source_index) >= CMPW'(total_elements);
      for (int k = 0; k < LAT; k++) begin
        idx[k+1] <= idx[k];
        val[k+1] <= val[k];
        oor[k+1] <= oor[k];
      end
    end
  end

  for (genvar d = 0; d < LANES; d++) begin : g_lane
    trag_lane #(
      .INDEX_BITS(INDEX_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .idx   (idx[0]),
      .cfg   (lane_cfg[d]),
      .delta (delta[d])
    );
  end

  always_comb begin
    offset = '0;
    for (int d = 0; d < LANES; d++) begin
      offset = offset + delta[d];
    end
  end

  assign keep_mask = {INDEX_BITS{1'b1}} >> (INDEX_BITS - KEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= vld[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld[LAT]) begin
      dest_index   <= (oor[LAT] ? idx[LAT] : idx[LAT] + offset) & keep_mask;
      moved_value  <= val[LAT];
      out_of_range <= oor[LAT];
    end
  end

endmodule
